// ----- rtl/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'(ENTRIES);
    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic [1:0] REG_CAPACITY = 2'd0;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic               hit;
        logic [ENTRIES-1:0] match;
        logic [IDX_W-1:0]   pos;
        word_t              stored;
    } lookup_t;

    // Positions below n set, the rest clear.
    function automatic logic [ENTRIES-1:0] prefix_mask(input logic [CNT_W-1:0] n);
        logic [ENTRIES-1:0] m;
        for (int i = 0; i < ENTRIES; i++)
        begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps

// Fully associative key-value cache of 16 entries with least-recently-used
// replacement. Requests arrive on the s_ stream: s_tuser selects get or put,
// s_tdata carries the key and the value. Each request gives exactly one result
// on the m_ stream: m_tuser carries the hit flag, m_tdata the read value and the
// occupancy after the request.
// A request is captured in an input register, served once the output register
// is free by a parallel key compare and a one-position shift of the recency
// chain, and the result lands in an output register. One request is taken
// every cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register, one more
// request waits in the input register, and s_tready then falls.
// Reset empties the chain, clears both registers and sets capacity to 16.
// The user must write capacity over the APB port at address 0 only while no
// request is in flight; the block does not enforce this. A lower capacity
// takes effect at the next request.
module lru_key_value_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]  s_tuser,   // func [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_value [31:0], occupancy [36:32], zero [39:37]
    output logic [0:0]  m_tuser,   // hit [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                          cap_reg, unused_dummy;
    logic [lkv_pkg::CNT_W-1:0]     capacity_reg, cap_eff;
    logic                          in_valid_reg, in_func_reg;
    lkv_pkg::word_t                in_key_reg, in_value_reg;
    logic                          out_valid_reg, out_hit_reg;
    lkv_pkg::word_t                out_read_reg;
    logic [lkv_pkg::CNT_W-1:0]     out_occ_reg;
    logic                          fire, s_accept, cfg_write;
    lkv_pkg::word_t                keys   [lkv_pkg::ENTRIES];
    lkv_pkg::word_t                values [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0]   valid_eff, valid_q;
    logic [lkv_pkg::CNT_W-1:0]     held_q, held_new;
    lkv_pkg::lookup_t              lookup;
    lkv_pkg::word_t                read_next;

    assign cap_reg      = 1'b0;
    assign unused_dummy = cap_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= lkv_pkg::CAP_RESET;
        else if (cfg_write && paddr[3:2] == lkv_pkg::REG_CAPACITY)
            capacity_reg <= pwdata[lkv_pkg::CNT_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[3:2] == lkv_pkg::REG_CAPACITY)
            prdata = {{(32-lkv_pkg::CNT_W){1'b0}}, capacity_reg};
    end

    always_comb
    begin
        if (capacity_reg == '0)
            cap_eff = lkv_pkg::CNT_W'(1);
        else if (capacity_reg > lkv_pkg::CNT_W'(lkv_pkg::ENTRIES))
            cap_eff = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
        else
            cap_eff = capacity_reg;
    end

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg  <= s_tuser[0];
            in_key_reg   <= s_tdata[31:0];
            in_value_reg <= s_tdata[63:32];
        end
    end

    lkv_lookup u_lookup (
        .key    (in_key_reg),
        .keys   (keys),
        .values (values),
        .valid  (valid_eff),
        .result (lookup)
    );

    lkv_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .func      (in_func_reg),
        .key       (in_key_reg),
        .value     (in_value_reg),
        .cap_eff   (cap_eff),
        .lookup    (lookup),
        .keys      (keys),
        .values    (values),
        .valid_eff (valid_eff),
        .valid_q   (valid_q),
        .held_q    (held_q),
        .held_new  (held_new)
    );

    always_comb
    begin
        if (in_func_reg == lkv_pkg::FUNC_PUT)
            read_next = '0;
        else if (lookup.hit)
            read_next = lookup.stored;
        else
            read_next = lkv_pkg::MISS_VALUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_hit_reg  <= lookup.hit;
            out_read_reg <= read_next;
            out_occ_reg  <= held_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_read_reg};
    assign m_tuser  = {out_hit_reg | unused_dummy};

    // The valid entries always form the prefix below the held count.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        valid_q == lkv_pkg::prefix_mask(held_q))
        else $error("valid bits do not match held count");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_q <= lkv_pkg::CNT_W'(lkv_pkg::ENTRIES))
        else $error("held count beyond entry count");

    // A miss reads either the put constant or the get miss marker.
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0 || m_tdata[31:0] == '1))
        else $error("miss result carries a stored value");

    a_hit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[36:32] != '0))
        else $error("hit reported with an empty cache");

endmodule

// ----- rtl/lkv_lookup.sv -----
// Parallel key compare across the recency chain with one-hot value select.
`timescale 1ns / 1ps

module lkv_lookup (
    input  lkv_pkg::word_t             key,
    input  lkv_pkg::word_t             keys   [lkv_pkg::ENTRIES],
    input  lkv_pkg::word_t             values [lkv_pkg::ENTRIES],
    input  logic [lkv_pkg::ENTRIES-1:0] valid,
    output lkv_pkg::lookup_t           result
);

    always_comb
    begin
        lkv_pkg::lookup_t r;
        r = '0;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            r.match[i] = valid[i] && (keys[i] == key);
        end
        // Keys are unique among valid entries, so the match is at most one-hot.
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (r.match[i])
            begin
                r.pos    = r.pos | lkv_pkg::IDX_W'(i);
                r.stored = r.stored | values[i];
            end
        end
        r.hit = |r.match;
        result = r;
    end

endmodule

// ----- rtl/lkv_store.sv -----
// Recency chain storage: truncation to capacity, move-to-front and insert with shift.
`timescale 1ns / 1ps

module lkv_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         func,
    input  lkv_pkg::word_t               key,
    input  lkv_pkg::word_t               value,
    input  logic [lkv_pkg::CNT_W-1:0]    cap_eff,
    input  lkv_pkg::lookup_t             lookup,
    output lkv_pkg::word_t               keys   [lkv_pkg::ENTRIES],
    output lkv_pkg::word_t               values [lkv_pkg::ENTRIES],
    output logic [lkv_pkg::ENTRIES-1:0]  valid_eff,
    output logic [lkv_pkg::ENTRIES-1:0]  valid_q,
    output logic [lkv_pkg::CNT_W-1:0]    held_q,
    output logic [lkv_pkg::CNT_W-1:0]    held_new
);

    lkv_pkg::word_t                keys_reg   [lkv_pkg::ENTRIES];
    lkv_pkg::word_t                values_reg [lkv_pkg::ENTRIES];
    lkv_pkg::word_t                keys_next   [lkv_pkg::ENTRIES];
    lkv_pkg::word_t                values_next [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0]   valid_reg, valid_next;
    logic [lkv_pkg::CNT_W-1:0]     held_reg, held_next;
    logic [lkv_pkg::CNT_W-1:0]     held_trunc, last;
    logic [lkv_pkg::ENTRIES-1:0]   shift;
    logic                          grow, write_front;
    lkv_pkg::word_t                front_value;

    always_comb
    begin
        // Positions at or beyond the capacity drop out before the request is served.
        valid_eff  = valid_reg & lkv_pkg::prefix_mask(cap_eff);
        held_trunc = (held_reg > cap_eff) ? cap_eff : held_reg;
        last       = (held_trunc < cap_eff) ? held_trunc : cap_eff - 1'b1;
        grow       = !lookup.hit && (func == lkv_pkg::FUNC_PUT) && (held_trunc < cap_eff);
        held_new   = held_trunc + lkv_pkg::CNT_W'(grow);
        write_front = lookup.hit || (func == lkv_pkg::FUNC_PUT);
        front_value = (func == lkv_pkg::FUNC_PUT) ? value : lookup.stored;

        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (i == 0)
                shift[i] = 1'b0;
            else if (lookup.hit)
                shift[i] = (lkv_pkg::IDX_W'(i) <= lookup.pos);
            else
                shift[i] = (func == lkv_pkg::FUNC_PUT) && (lkv_pkg::CNT_W'(i) <= last);
        end

        valid_next = valid_eff;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            keys_next[i]   = keys_reg[i];
            values_next[i] = values_reg[i];
        end
        if (write_front)
        begin
            keys_next[0]   = key;
            values_next[0] = front_value;
            valid_next[0]  = 1'b1;
        end
        for (int i = 1; i < lkv_pkg::ENTRIES; i++)
        begin
            if (shift[i])
            begin
                keys_next[i]   = keys_reg[i-1];
                values_next[i] = values_reg[i-1];
                valid_next[i]  = valid_eff[i-1];
            end
        end
        held_next = held_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            held_reg  <= '0;
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            begin
                keys_reg[i]   <= keys_next[i];
                values_reg[i] <= values_next[i];
            end
        end
    end

    assign keys    = keys_reg;
    assign values  = values_reg;
    assign valid_q = valid_reg;
    assign held_q  = held_reg;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the LRU key-value cache: directed and random request streams.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 135;
    localparam int POOL_SIZE      = 32;

    // Slot indices and the capacity byte address; only the first slot holds a register.
    localparam logic [1:0] REG_PAST_END  = lkv_pkg::REG_CAPACITY + 2'd1;
    localparam logic [1:0] REG_LAST_SLOT = 2'd3;
    localparam logic [3:0] ADDR_CAPACITY = {lkv_pkg::REG_CAPACITY, 2'b00};

    typedef enum int {
        RECV_ALWAYS,
        RECV_RANDOM,
        RECV_SPARSE,
        RECV_PERIODIC
    } recv_mode_t;

    typedef struct {
        logic                      hit;
        lkv_pkg::word_t            read_value;
        logic [lkv_pkg::CNT_W-1:0] occupancy;
    } cache_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // key [31:0], value [63:32]
    logic [0:0]  s_tuser = '0;   // func [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // read_value [31:0], occupancy [36:32], zero [39:37]
    logic [0:0]  m_tuser;        // hit [0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lru_key_value_cache uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the recency chain; position 0 is the most recent entry.
    lkv_pkg::word_t            chain_key [lkv_pkg::ENTRIES];
    lkv_pkg::word_t            chain_val [lkv_pkg::ENTRIES];
    int                        chain_held = 0;
    logic [lkv_pkg::CNT_W-1:0] capacity_reg = lkv_pkg::CAP_RESET;

    cache_result_t             pending_results [$];
    cache_result_t             oldest_result;
    cache_result_t             predicted;
    lkv_pkg::word_t            key_pool [POOL_SIZE];

    recv_mode_t       recv_mode = RECV_ALWAYS;
    int               gap_max = 0;
    int               burst_left = 0;
    int               fail_count = 0;
    int               request_count = 0;
    int               hit_count = 0;
    int               evict_count = 0;
    int               capacity_writes = 0;
    int               stall_cycles = 0;
    int               cycle_count = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Updates the shadow chain for one request and returns the result it gives.
    function automatic cache_result_t predict_request(input logic func,
                                                      input lkv_pkg::word_t key,
                                                      input lkv_pkg::word_t value);
        cache_result_t  res;
        int             limit;
        int             pos;
        int             last;
        int             i;
        lkv_pkg::word_t stored;

        limit = (capacity_reg == 0) ? 1 :
                ((capacity_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : capacity_reg);
        if (chain_held > limit)
            chain_held = limit;
        pos = -1;
        for (i = 0; i < chain_held; i++)
        begin
            if (pos < 0 && chain_key[i] == key)
                pos = i;
        end
        res.hit = (pos >= 0);
        if (pos >= 0)
        begin
            stored = chain_val[pos];
            for (i = pos; i > 0; i--)
            begin
                chain_key[i] = chain_key[i-1];
                chain_val[i] = chain_val[i-1];
            end
            chain_key[0] = key;
            chain_val[0] = (func == lkv_pkg::FUNC_PUT) ? value : stored;
            res.read_value = (func == lkv_pkg::FUNC_PUT) ? '0 : stored;
            hit_count++;
        end
        else if (func == lkv_pkg::FUNC_PUT)
        begin
            last = (chain_held < limit) ? chain_held : limit - 1;
            for (i = last; i > 0; i--)
            begin
                chain_key[i] = chain_key[i-1];
                chain_val[i] = chain_val[i-1];
            end
            chain_key[0] = key;
            chain_val[0] = value;
            if (chain_held < limit)
                chain_held++;
            else
                evict_count++;
            res.read_value = '0;
        end
        else
        begin
            res.read_value = lkv_pkg::MISS_VALUE;
        end
        res.occupancy = lkv_pkg::CNT_W'(chain_held);
        return res;
    endfunction

    // Offers one request, waits for its transfer, and, when gap_max is set, inserts idle gaps between bursts.
    task automatic send_request(input logic func, input lkv_pkg::word_t key,
                                input lkv_pkg::word_t value);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {value, key};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_request(func, key, value);
        pending_results.insert(pending_results.size(), predicted);
        request_count++;
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge clk);
                burst_left = $urandom_range(12, 0);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_capacity_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {27'd0, capacity_reg})
        begin
            $display("%0t: capacity readback mismatch, expected %h actual %h",
                     $time, {27'd0, capacity_reg}, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register writes happen only once every outstanding result has been taken.
    task automatic write_register(input logic [1:0] reg_index, input logic [31:0] data);
        wait_for_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == lkv_pkg::REG_CAPACITY)
        begin
            capacity_reg = data[lkv_pkg::CNT_W-1:0];
            capacity_writes++;
        end
        @(posedge clk);
        check_capacity_readback();
    endtask

    // Compare each result transfer against the oldest pending prediction.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual hit %b value %h occupancy %0d",
                         $time, m_tuser[0], m_tdata[31:0], m_tdata[36:32]);
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results[0];
                pending_results.delete(0);
                if (m_tuser[0] !== oldest_result.hit)
                begin
                    $display("%0t: hit mismatch, expected %b actual %b",
                             $time, oldest_result.hit, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata[31:0] !== oldest_result.read_value)
                begin
                    $display("%0t: read_value mismatch, expected %h actual %h",
                             $time, oldest_result.read_value, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[36:32] !== oldest_result.occupancy)
                begin
                    $display("%0t: occupancy mismatch, expected %0d actual %0d",
                             $time, oldest_result.occupancy, m_tdata[36:32]);
                    fail_count++;
                end
            end
        end
        case (recv_mode)
            RECV_ALWAYS:   m_tready <= 1'b1;
            RECV_RANDOM:   m_tready <= ($urandom_range(1, 0) == 1);
            RECV_SPARSE:   m_tready <= ($urandom_range(3, 0) == 0);
            default:       m_tready <= ((cycle_count % 9) < 5);
        endcase
    end

    // A run that stops transferring anything for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic test_get_put_basics();
        recv_mode = RECV_ALWAYS;
        gap_max   = 0;
        send_request(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(lkv_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lkv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(lkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lkv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h5555_AAAA);
    endtask

    task automatic test_capacity_edges();
        recv_mode = RECV_RANDOM;
        write_register(lkv_pkg::REG_CAPACITY, 32'd1);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_00A1, 32'h0000_1111);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_00B2, 32'h0000_2222);
        send_request(lkv_pkg::FUNC_GET, 32'h0000_00A1, 32'h0);
        send_request(lkv_pkg::FUNC_GET, 32'h0000_00B2, 32'h0);
        // A capacity of zero acts like one.
        write_register(lkv_pkg::REG_CAPACITY, 32'd0);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_00C3, 32'h0000_3333);
        send_request(lkv_pkg::FUNC_GET, 32'h0000_00B2, 32'h0);
        write_register(lkv_pkg::REG_CAPACITY, 32'd31);
        write_register(lkv_pkg::REG_CAPACITY, 32'd4);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_0D01, 32'hD000_0001);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_0D02, 32'hD000_0002);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_0D03, 32'hD000_0003);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_0D04, 32'hD000_0004);
        // Lowering the capacity truncates the chain at the next request.
        write_register(lkv_pkg::REG_CAPACITY, 32'd2);
        send_request(lkv_pkg::FUNC_GET, 32'h0000_0D01, 32'h0);
        send_request(lkv_pkg::FUNC_GET, 32'h0000_0D04, 32'h0);
        // Writes to unused register slots must leave the capacity alone.
        write_register(REG_PAST_END, 32'd1);
        write_register(REG_LAST_SLOT, 32'hFFFF_FFFF);
        send_request(lkv_pkg::FUNC_PUT, 32'h0000_0E05, 32'hE000_0005);
        send_request(lkv_pkg::FUNC_GET, 32'h0000_0D04, 32'h0);
    endtask

    task automatic test_random_traffic();
        int             phase_caps [PHASE_COUNT] = '{16, 1, 4, 31, 0, 8, 2, 16, 17, 12, 3, 16};
        int             phase;
        int             item;
        int             cap_eff;
        int             pool_n;
        int             i;
        logic           func;
        lkv_pkg::word_t key;

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_register(lkv_pkg::REG_CAPACITY, phase_caps[phase]);
            cap_eff   = (phase_caps[phase] == 0) ? 1 :
                        ((phase_caps[phase] > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES :
                         phase_caps[phase]);
            pool_n    = (phase == 5) ? POOL_SIZE : cap_eff + $urandom_range(6, 1);
            recv_mode = recv_mode_t'(phase % 4);
            gap_max   = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 10);
            for (i = 0; i < POOL_SIZE; i++)
                key_pool[i] = $urandom;
            if (phase % 2 == 0)
            begin
                key_pool[0] = 32'h0000_0000;
                key_pool[1] = 32'hFFFF_FFFF;
                key_pool[2] = 32'h8000_0000;
                key_pool[3] = 32'h7FFF_FFFF;
            end
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                if (phase == 2 && item == PHASE_ITEMS / 2)
                    wait_for_drain();
                func = ($urandom_range(99, 0) < 55) ? lkv_pkg::FUNC_PUT : lkv_pkg::FUNC_GET;
                if ($urandom_range(99, 0) < 85)
                    key = key_pool[$urandom_range(pool_n - 1, 0)];
                else
                    key = $urandom;
                send_request(func, key, $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_get_put_basics();
        test_capacity_edges();
        test_random_traffic();
        wait_for_drain();
        repeat (10) @(posedge clk);
        $display("Checked %0d requests with %0d hits and %0d evictions",
                 request_count, hit_count, evict_count);
        $display("across %0d capacity writes, with sender gaps and receiver stalls varied.",
                 capacity_writes);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
